>>> design/wheel_quadrature_detent_decoder_core_defines.svh
// Assertion macros shared by the wheel decoder RTL.
// Define ASSERT_OFF to compile them away.
`ifndef WHEEL_QUADRATURE_DETENT_DECODER_CORE_DEFINES_SVH
`define WHEEL_QUADRATURE_DETENT_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define WQDD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wqdd assertion failed");
`define WQDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wqdd assertion failed");
`else
`define WQDD_ASSERT_NOW(lbl, ante, cons)
`define WQDD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> design/wqdd_pkg.sv
`default_nettype none

package wqdd_pkg;

  // Pin level codes, B in bit 1 and A in bit 0
  localparam logic [1:0] LVL_LL = 2'b00;
  localparam logic [1:0] LVL_LH = 2'b01;
  localparam logic [1:0] LVL_HL = 2'b10;
  localparam logic [1:0] LVL_HH = 2'b11;

  // Debounced level
  typedef enum logic [1:0] {
    SET_NONE = 2'd0,
    SET_LL   = 2'd1,
    SET_HH   = 2'd2
  } settled_t;

  // Detent direction codes
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned SETTLE_W   = 4;
  localparam logic        REG_SETTLE_SAMPLES = 1'b0;  // word index, paddr[2]
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 4'd4;

endpackage

`default_nettype wire

>>> design/wqdd_in_if.sv
`default_nettype none

// Pin sample channel
interface wqdd_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;

  modport source (output valid, output pin_a, output pin_b, input ready);
  modport sink   (input valid, input pin_a, input pin_b, output ready);
endinterface

`default_nettype wire

>>> design/wqdd_out_if.sv
`default_nettype none

// Detent event channel
interface wqdd_out_if;
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

`default_nettype wire

>>> design/wheel_quadrature_detent_decoder_core.sv
// Wheel quadrature detent decoder.
// in_chan carries one sample of encoder pins A and B per item; out_chan
// carries one detent event (direction 0 clockwise, 1 counterclockwise) for
// each sample that completes a debounced step, and nothing for other samples.
// Both channels use valid/ready; an item moves when both are high.
// The APB port holds settle_samples at address 0 (reset value 4); write it
// only while the block is idle.
// Throughput: one sample per cycle while the skid register is empty. The decoder
// state is updated in the cycle a sample is accepted, and an event appears on
// out_chan the next cycle when the result register is free, else it waits in a one-entry skid register.
// If the receiver stalls, samples are still taken until a second event is
// waiting; in_chan.ready drops only while the skid register holds an event,
// and rises the cycle after the receiver takes an item.
// Synchronous active-low reset clears the decoder to "not primed", empties
// the result and skid registers and restores settle_samples to 4; the first
// sample afterwards only records the pin levels.
`default_nettype none
`include "wheel_quadrature_detent_decoder_core_defines.svh"

module wheel_quadrature_detent_decoder_core
  import wqdd_pkg::*;
#(
  parameter int COUNT_WIDTH = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  wqdd_in_if.sink               in_chan,
  wqdd_out_if.source            out_chan,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [APB_ADDR_W-1:0] paddr,
  input  wire  [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CMP_W   = (COUNT_WIDTH > SETTLE_W) ? COUNT_WIDTH : SETTLE_W;
  localparam int CNT_MAX = (1 << COUNT_WIDTH) - 1;
  localparam int RST_CNT = (int'(SETTLE_RESET) > CNT_MAX) ? CNT_MAX : int'(SETTLE_RESET);

  // Configuration register
  logic [SETTLE_W-1:0] settle_samples_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SETTLE_SAMPLES);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SETTLE_SAMPLES) begin
      prdata = APB_DATA_W'(settle_samples_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_samples_r <= SETTLE_RESET;
    end else if (cfg_wr) begin
      settle_samples_r <= pwdata[SETTLE_W-1:0];
    end
  end

  // Decoder state
  logic                   primed_r,   primed_nxt;
  logic [1:0]             last_lv_r,  last_lv_nxt;
  settled_t               settled_r,  settled_nxt;
  logic [COUNT_WIDTH-1:0] count_r,    count_nxt;
  logic                   pend_cw_r,  pend_cw_nxt;
  logic                   pend_ccw_r, pend_ccw_nxt;

  // Result register and skid entry
  logic out_valid_r,  out_valid_nxt;
  logic out_dir_r,    out_dir_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic skid_dir_r,   skid_dir_nxt;

  logic                   in_acc;
  logic                   pop;
  logic [1:0]             lv;
  logic [CMP_W-1:0]       settle_ext;
  logic [COUNT_WIDTH-1:0] reload;
  logic                   just;
  logic                   emit;
  logic                   emit_dir;
  logic                   cw;
  settled_t               target;

  assign in_chan.ready  = !skid_valid_r;
  assign in_acc         = in_chan.valid && !skid_valid_r;
  assign out_chan.valid = out_valid_r;
  assign out_chan.direction = out_dir_r;
  assign pop            = !out_valid_r || out_chan.ready;
  assign lv             = {in_chan.pin_b, in_chan.pin_a};

  // Reload value, saturated to the counter range
  assign settle_ext = CMP_W'(settle_samples_r);
  assign reload = (settle_ext > CMP_W'(CNT_MAX)) ? COUNT_WIDTH'(CNT_MAX)
                                                 : settle_ext[COUNT_WIDTH-1:0];

  // Per-sample next state
  always_comb begin
    primed_nxt   = primed_r;
    last_lv_nxt  = last_lv_r;
    settled_nxt  = settled_r;
    count_nxt    = count_r;
    pend_cw_nxt  = pend_cw_r;
    pend_ccw_nxt = pend_ccw_r;
    just         = 1'b0;
    emit         = 1'b0;
    emit_dir     = DIR_CW;
    cw           = 1'b0;
    target       = (lv == LVL_LL) ? SET_LL : SET_HH;

    if (!primed_r) begin
      // first sample only records the levels
      primed_nxt  = 1'b1;
      last_lv_nxt = lv;
      settled_nxt = SET_NONE;
      count_nxt   = reload;
    end else begin
      if (lv == LVL_LL || lv == LVL_HH) begin
        if (settled_r != target && last_lv_r == lv && count_r != '0) begin
          count_nxt = count_r - 1'b1;
          if (count_r == COUNT_WIDTH'(1)) begin
            settled_nxt = target;
            just        = 1'b1;
          end
        end
      end else begin
        count_nxt = reload;
        if (settled_r == SET_LL || settled_r == SET_HH) begin
          cw           = (lv == LVL_LH) == (settled_r == SET_LL);
          pend_cw_nxt  = cw;
          pend_ccw_nxt = !cw;
        end
      end
      last_lv_nxt = lv;

      // settling with a direction pending gives one event
      if (just) begin
        if (pend_cw_r) begin
          pend_cw_nxt = 1'b0;
          emit        = 1'b1;
          emit_dir    = DIR_CW;
        end else if (pend_ccw_r) begin
          pend_ccw_nxt = 1'b0;
          emit         = 1'b1;
          emit_dir     = DIR_CCW;
        end
      end
    end
  end

  // Output buffering
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_dir_nxt    = out_dir_r;
    skid_valid_nxt = skid_valid_r;
    skid_dir_nxt   = skid_dir_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_dir_nxt    = skid_dir_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_acc && emit;
        out_dir_nxt   = emit_dir;
      end
    end else if (in_acc && emit) begin
      skid_valid_nxt = 1'b1;
      skid_dir_nxt   = emit_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r     <= 1'b0;
      last_lv_r    <= LVL_LL;
      settled_r    <= SET_NONE;
      count_r      <= COUNT_WIDTH'(RST_CNT);
      pend_cw_r    <= 1'b0;
      pend_ccw_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        primed_r   <= primed_nxt;
        last_lv_r  <= last_lv_nxt;
        settled_r  <= settled_nxt;
        count_r    <= count_nxt;
        pend_cw_r  <= pend_cw_nxt;
        pend_ccw_r <= pend_ccw_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dir_r  <= out_dir_nxt;
    skid_dir_r <= skid_dir_nxt;
  end

  // Checks
  `WQDD_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `WQDD_ASSERT_NOW(a_pend_exclusive, 1'b1, !(pend_cw_r && pend_ccw_r))
  `WQDD_ASSERT_NOW(a_unprimed_clean, !primed_r,
                   settled_r == SET_NONE && !pend_cw_r && !pend_ccw_r)
  `WQDD_ASSERT_NEXT(a_event_settles, in_acc && emit,
                    settled_r != SET_NONE && out_valid_r)

endmodule

`default_nettype wire

>>> tb/sv/wqdd_detent_checker.sv
`timescale 1ns / 1ps

// Watches the sample, detent and APB traffic, predicts the detent events and
// compares them with what the decoder emits.
module wqdd_detent_checker
  import wqdd_pkg::*;
#(
  parameter int COUNT_WIDTH = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  wqdd_in_if                   in_mon,
  wqdd_out_if                  out_mon,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [APB_ADDR_W-1:0] paddr,
  input  wire [APB_DATA_W-1:0] pwdata,
  input  wire [APB_DATA_W-1:0] prdata,
  input  wire                  pready,
  output int                   fail_count,
  output int                   pending_count
);

  localparam int CNT_MAX = (1 << COUNT_WIDTH) - 1;

  // Shadow of the threshold register and of the decoder state
  logic [SETTLE_W-1:0]    settle_reg;
  logic                   primed;
  logic [1:0]             prev_lv;
  settled_t               settled;
  logic [COUNT_WIDTH-1:0] remain;
  logic                   pend_cw;
  logic                   pend_ccw;

  // Detent directions still to be emitted, oldest first
  logic detent_q[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Threshold as loaded into the counter, saturated to the counter width
  function automatic logic [COUNT_WIDTH-1:0] reload_count();
    if (int'(settle_reg) > CNT_MAX) return COUNT_WIDTH'(CNT_MAX);
    return COUNT_WIDTH'(settle_reg);
  endfunction

  task automatic note_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Advance the shadow decoder by one pin sample
  task automatic advance_decoder(input logic a, input logic b);
    logic [1:0] lv;
    settled_t   target;
    logic       just;
    lv   = {b, a};
    just = 1'b0;
    if (!primed) begin
      // first sample only records the levels
      primed  = 1'b1;
      prev_lv = lv;
      settled = SET_NONE;
      remain  = reload_count();
      return;
    end
    if (lv == LVL_LL || lv == LVL_HH) begin
      target = (lv == LVL_LL) ? SET_LL : SET_HH;
      if (settled != target && prev_lv == lv && remain != '0) begin
        remain = remain - 1'b1;
        if (remain == '0) begin
          settled = target;
          just    = 1'b1;
        end
      end
    end else begin
      // intermediate level: reload, and arm only from a settled level
      remain = reload_count();
      if (settled == SET_LL || settled == SET_HH) begin
        pend_cw  = ((lv == LVL_LH) == (settled == SET_LL));
        pend_ccw = !pend_cw;
      end
    end
    prev_lv = lv;
    if (just) begin
      if (pend_cw) begin
        pend_cw = 1'b0;
        detent_q.push_back(DIR_CW);
      end else if (pend_ccw) begin
        pend_ccw = 1'b0;
        detent_q.push_back(DIR_CCW);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      settle_reg = SETTLE_RESET;
      primed     = 1'b0;
      prev_lv    = LVL_LL;
      settled    = SET_NONE;
      remain     = reload_count();
      pend_cw    = 1'b0;
      pend_ccw   = 1'b0;
      detent_q.delete();
    end else begin
      // detent item leaving the decoder
      if (out_mon.valid && out_mon.ready) begin
        if (detent_q.size() == 0) begin
          note_mismatch($sformatf("detent %0b with none expected", out_mon.direction));
        end else if (out_mon.direction !== detent_q[0]) begin
          note_mismatch($sformatf("direction expected %0b got %0b",
                                  detent_q[0], out_mon.direction));
          void'(detent_q.pop_front());
        end else begin
          void'(detent_q.pop_front());
        end
      end
      // register traffic
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_SETTLE_SAMPLES) settle_reg = pwdata[SETTLE_W-1:0];
        end else if (paddr[2] == REG_SETTLE_SAMPLES &&
                     prdata[SETTLE_W-1:0] !== settle_reg) begin
          note_mismatch($sformatf("settle_samples read expected %0d got %0d",
                                  settle_reg, prdata[SETTLE_W-1:0]));
        end
      end
      // pin sample entering the decoder
      if (in_mon.valid && in_mon.ready) advance_decoder(in_mon.pin_a, in_mon.pin_b);
    end
    pending_count = detent_q.size();
  end

endmodule

>>> tb/sv/tb_wheel_quadrature_detent_decoder_core.sv
`timescale 1ns / 1ps

module tb_wheel_quadrature_detent_decoder_core;
  import wqdd_pkg::*;

  localparam int COUNT_WIDTH     = 4;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam logic [APB_ADDR_W-1:0] ADDR_SETTLE = {REG_SETTLE_SAMPLES, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE  = {!REG_SETTLE_SAMPLES, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  no_idle;
  logic                  hold_off_req;
  int                    fail_count;
  int                    pending_count;

  wqdd_in_if  in_chan ();
  wqdd_out_if out_chan ();

  wheel_quadrature_detent_decoder_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wqdd_detent_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("wheel_quadrature_detent_decoder_core test failed");
    $finish;
  end

  // Detent receiver: free stretches, stall bursts and one long hold-off
  initial begin : detent_ready_gen
    int n;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_chan.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (no_idle || $urandom_range(0, 1)) begin
        out_chan.ready = 1'b1;
        if (!no_idle) begin
          n = $urandom_range(1, 20);
          repeat (n - 1) @(negedge clk);
        end
      end else begin
        out_chan.ready = 1'b0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // One pin sample item, with an occasional gap in front; returns at a negedge
  task automatic send_sample(input logic [1:0] lv);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.pin_a = lv[0];
    in_chan.pin_b = lv[1];
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Drain: every detent out, then wait for the decoder to go quiet
  task automatic wait_drained();
    in_chan.valid = 1'b0;
    wait (pending_count == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                          input logic [APB_DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Wheel motion: mostly clean detents with bounce, some broken runs and noise
  task automatic run_motion(input int n_items, input int thr);
    int         sent;
    int         reps;
    logic [1:0] cur;
    logic [1:0] other;
    logic [1:0] mid;
    logic [1:0] lv;
    cur  = LVL_LL;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        other = (cur == LVL_LL) ? LVL_HH : LVL_LL;
        mid   = $urandom_range(0, 1) ? LVL_LH : LVL_HL;
        // contact bounce back to the old level
        if ($urandom_range(0, 3) == 0) begin
          send_sample(mid);
          send_sample(cur);
          sent += 2;
        end
        reps = $urandom_range(1, 2);
        repeat (reps) send_sample(mid);
        sent += reps;
        reps = thr + 1 + $urandom_range(0, 2);
        // run cut short now and then
        if ($urandom_range(0, 7) == 0) reps = $urandom_range(1, thr + 1);
        repeat (reps) send_sample(other);
        sent += reps;
        cur = other;
      end else begin
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          lv = 2'($urandom_range(0, 3));
          send_sample(lv);
          if (lv == LVL_LL || lv == LVL_HH) cur = lv;
        end
        sent += reps;
      end
    end
  endtask

  // Write the threshold, read it back, then run one phase of motion
  task automatic run_phase(input logic [APB_DATA_W-1:0] data, input int n_items);
    apb_xfer(1'b1, ADDR_SETTLE, data);
    apb_xfer(1'b0, ADDR_SETTLE, '0);
    run_motion(n_items, int'(data[SETTLE_W-1:0]));
    wait_drained();
  endtask

  initial begin : stimulus
    logic [APB_DATA_W-1:0] data;
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.pin_a = 1'b0;
    in_chan.pin_b = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_idle       = 1'b0;
    hold_off_req  = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset threshold readback
    apb_xfer(1'b0, ADDR_SETTLE, '0);

    // Directed, threshold 4: first sample, intermediate with nothing settled,
    // clockwise detent, skipped intermediate, counterclockwise detent
    send_sample(LVL_LH);
    send_sample(LVL_LH);
    repeat (5) send_sample(LVL_LL);
    send_sample(LVL_LH);
    repeat (5) send_sample(LVL_HH);
    repeat (3) send_sample(LVL_LL);
    send_sample(LVL_LH);
    repeat (5) send_sample(LVL_LL);
    wait_drained();

    // spare address is ignored
    apb_xfer(1'b1, ADDR_SPARE, '1);
    apb_xfer(1'b0, ADDR_SETTLE, '0);

    // receiver holds off while samples keep coming, so the input stalls
    apb_xfer(1'b1, ADDR_SETTLE, 32'd1);
    hold_off_req = 1'b1;
    run_motion(60, 1);
    wait_drained();

    // widest threshold, zero threshold with upper bits set, then others
    run_phase(32'h0000_000F, 100);
    run_phase(32'hFFFF_FFF0, 60);
    run_phase(32'd2, 100);
    run_phase(32'hA5A5_A5A7, 80);
    run_phase(32'd3, 80);
    data = $urandom();
    data[SETTLE_W-1:0] = 4'($urandom_range(1, 15));
    run_phase(data, 60);

    // closing stretch with no idling on either side
    no_idle = 1'b1;
    run_phase(32'd1, 60);

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("wheel_quadrature_detent_decoder_core test passed");
    end else begin
      $display("wheel_quadrature_detent_decoder_core test failed");
    end
    $finish;
  end

endmodule
